>>> src/assert_macros.svh
// Assertion macros for the RTL of the bencode tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define BST_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BST_ASSERT(lbl, clk, rst_n, prop, msg)
`define BST_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> src/bst_pkg.sv
// Constants for the bencode stream tokenizer.
`default_nettype none
package bst_pkg;

  // Event codes of a result
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_INT   = 3'd1;
  localparam logic [2:0] EV_LEN   = 3'd2;
  localparam logic [2:0] EV_BYTE  = 3'd3;
  localparam logic [2:0] EV_LIST  = 3'd4;
  localparam logic [2:0] EV_DICT  = 3'd5;
  localparam logic [2:0] EV_CLOSE = 3'd6;
  localparam logic [2:0] EV_ERR   = 3'd7;

  // Bencode syntax bytes
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // Register map: word index taken from paddr[2]
  localparam logic REG_INT_LIMIT = 1'b0;
  localparam logic [31:0] INT_LIMIT_RST = 32'h0002_0000;

endpackage
`default_nettype wire

>>> src/bencode_stream_tokenizer.sv
// Top level of the bencode stream tokenizer: one byte in, one event out.
`default_nettype none
`include "assert_macros.svh"

// Streaming bencode tokenizer. Each accepted byte produces exactly one result
// request carrying an event code (none, integer done, string length, string
// byte, list open, dict open, close, error), a 32-bit value, the nesting depth
// after the byte, a key-position flag and a top-level-item-done flag. No tree
// is built. Throughput is one byte per clock while out_stall_i is low; a
// byte passes the input register, then the result register. The per-byte
// work (mode decode, the accumulate step acc*10+digit as two shifts and an
// add, the limit compare, the stack-top update) is combinational, which is what
// sets the one-byte-per-clock rate. The container stack lives in a small RAM
// of DEPTH entries of {kind, toggle}; the open level is kept in flops and the
// level below it is prefetched from the RAM every cycle, so a close never
// waits. The stack needs no clearing pass after reset: a level is only read
// after it was pushed. Errors (integer above int_limit, bad byte, key that is
// not a string, dangling key, close at depth 0, nesting beyond DEPTH) are
// sticky; every later byte reports error until reset. The user must write
// int_limit (APB port, byte address 0) only while idle; it is not enforced.
module bencode_stream_tokenizer
  import bst_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Byte input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  // Event output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  event_res_o,
  output logic      [31:0] value_o,
  output logic      [4:0]  depth_o,
  output logic             is_key_o,
  output logic             item_done_o
);

  localparam int unsigned NW = $clog2(DEPTH + 1);         // depth counter
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1; // stack index

  typedef enum logic [1:0] {
    MODE_ITEM,
    MODE_INT,
    MODE_LEN,
    MODE_DATA
  } mode_e;

  // ---------------- configuration ----------------
  logic [31:0] int_limit_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_INT_LIMIT) ? int_limit_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_limit_q <= INT_LIMIT_RST;
    end else if (cfg_wr && (paddr[2] == REG_INT_LIMIT)) begin
      int_limit_q <= pwdata;
    end
  end

  // ---------------- state ----------------
  mode_e       mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [NW-1:0] nest_q, nest_d;
  logic        err_q, err_d;
  logic        top_kind_q, top_kind_d;   // 1 = dictionary
  logic        top_tog_q, top_tog_d;     // 1 = value position
  logic        fwd_q, fwd_d;             // below-top level is in fwd_data_q
  logic [1:0]  fwd_data_q;

  // Pipeline registers
  logic        v1_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic [2:0]  out_event_q;
  logic [31:0] out_value_q;
  logic [4:0]  out_depth_q;
  logic        out_key_q;
  logic        out_done_q;

  // Handshake: step when the input register holds a byte and the result
  // register is free or being drained this cycle.
  logic step, in_acc;
  assign step       = v1_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = v1_q && !step;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------- stack RAM ----------------
  logic          push;
  logic          ram_we;
  logic [NW-1:0] wr_lvl, rd_lvl;
  logic [1:0]    ram_rdata;
  logic [1:0]    below;

  assign wr_lvl = nest_q - NW'(1);
  assign rd_lvl = nest_d - NW'(2);
  assign ram_we = step && push && (nest_q != '0);
  // The level under the top: just-pushed old top, else the prefetched entry.
  assign below  = fwd_q ? fwd_data_q : ram_rdata;

  bst_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_lvl[AW-1:0]),
    .wdata_i ({top_kind_q, top_tog_q}),
    .raddr_i (rd_lvl[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------- per-byte logic ----------------
  logic [35:0] acc_x10;
  logic        is_digit;
  logic        in_key;
  logic [31:0] rem_dec;
  logic [2:0]  ev;
  logic [31:0] val;
  logic        key, done;
  logic [NW+4:0] depth_ext;

  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {32'd0, byte_q[3:0]};
  assign is_digit = (byte_q >= CH_0) && (byte_q <= CH_9);
  assign in_key   = (nest_q != '0) && top_kind_q && !top_tog_q;
  assign rem_dec  = rem_q - 32'd1;

  always_comb begin
    mode_d     = mode_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    nest_d     = nest_q;
    err_d      = err_q;
    top_kind_d = top_kind_q;
    top_tog_d  = top_tog_q;
    push       = 1'b0;
    ev         = EV_NONE;
    val        = 32'd0;
    key        = 1'b0;
    done       = 1'b0;

    if (step && !err_q) begin
      unique case (mode_q)
        MODE_ITEM: begin
          if (byte_q == CH_I || byte_q == CH_L || byte_q == CH_D) begin
            if (in_key) begin
              err_d = 1'b1;               // keys must be strings
            end else if (byte_q == CH_I) begin
              mode_d = MODE_INT;
              acc_d  = 32'd0;
            end else if (nest_q >= NW'(DEPTH)) begin
              err_d = 1'b1;               // too deep
            end else begin
              push       = 1'b1;
              top_kind_d = (byte_q == CH_D);
              top_tog_d  = 1'b0;
              nest_d     = nest_q + NW'(1);
              ev         = (byte_q == CH_D) ? EV_DICT : EV_LIST;
            end
          end else if (byte_q == CH_E) begin
            if (nest_q == '0) begin
              err_d = 1'b1;               // close with nothing open
            end else if (top_kind_q && top_tog_q) begin
              err_d = 1'b1;               // key without value
            end else begin
              nest_d = nest_q - NW'(1);
              ev     = EV_CLOSE;
              if (nest_q == NW'(1)) begin
                done = 1'b1;
              end else begin
                top_kind_d = below[1];
                top_tog_d  = ~below[0];
              end
            end
          end else if (is_digit) begin
            mode_d = MODE_LEN;
            acc_d  = {28'd0, byte_q[3:0]};
          end else begin
            err_d = 1'b1;
          end
        end
        MODE_INT: begin
          if (byte_q == CH_E) begin
            key    = in_key;
            ev     = EV_INT;
            val    = acc_q;
            mode_d = MODE_ITEM;
            if (nest_q == '0) done = 1'b1;
            else top_tog_d = ~top_tog_q;
          end else if (is_digit) begin
            if (acc_x10 > {4'd0, int_limit_q}) err_d = 1'b1;
            else acc_d = acc_x10[31:0];
          end else begin
            err_d = 1'b1;
          end
        end
        MODE_LEN: begin
          if (byte_q == CH_COLON) begin
            key = in_key;
            ev  = EV_LEN;
            val = acc_q;
            if (acc_q == 32'd0) begin
              // empty string completes here
              mode_d = MODE_ITEM;
              if (nest_q == '0) done = 1'b1;
              else top_tog_d = ~top_tog_q;
            end else begin
              rem_d  = acc_q;
              mode_d = MODE_DATA;
            end
          end else if (is_digit) begin
            if (acc_x10[35:32] != 4'd0) err_d = 1'b1;
            else acc_d = acc_x10[31:0];
          end else begin
            err_d = 1'b1;
          end
        end
        MODE_DATA: begin
          key   = in_key;
          ev    = EV_BYTE;
          val   = {24'd0, byte_q};
          rem_d = rem_dec;
          if (rem_dec == 32'd0) begin
            mode_d = MODE_ITEM;
            if (nest_q == '0) done = 1'b1;
            else top_tog_d = ~top_tog_q;
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    if (step && err_d) begin
      ev   = EV_ERR;
      val  = 32'd0;
      key  = 1'b0;
      done = 1'b0;
    end

    fwd_d = step ? push : fwd_q;
  end

  assign depth_ext = {5'd0, nest_d};

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_ITEM;
      acc_q       <= 32'd0;
      rem_q       <= 32'd0;
      nest_q      <= '0;
      err_q       <= 1'b0;
      fwd_q       <= 1'b0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      rem_q  <= rem_d;
      nest_q <= nest_d;
      err_q  <= err_d;
      fwd_q  <= fwd_d;

      if (in_acc) v1_q <= 1'b1;
      else if (step) v1_q <= 1'b0;

      if (step) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    top_kind_q <= top_kind_d;
    top_tog_q  <= top_tog_d;
    if (step && push) fwd_data_q <= {top_kind_q, top_tog_q};
    if (in_acc) byte_q <= byte_in_i;
    if (step) begin
      out_event_q <= ev;
      out_value_q <= val;
      out_depth_q <= depth_ext[4:0];
      out_key_q   <= key;
      out_done_q  <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_event_q;
  assign value_o     = out_value_q;
  assign depth_o     = out_depth_q;
  assign is_key_o    = out_key_q;
  assign item_done_o = out_done_q;

  // ---------------- assertions ----------------
  `BST_ASSERT(a_err_sticky, clk_i, rst_ni, err_q |=> err_q, "error flag cleared")
  `BST_NEVER(a_depth_range, clk_i, rst_ni, nest_q > NW'(DEPTH), "nesting beyond DEPTH")
  `BST_ASSERT(a_data_rem, clk_i, rst_ni, (mode_q == MODE_DATA && !err_q) |-> (rem_q != 32'd0), "string data with no bytes left")
  `BST_ASSERT(a_err_payload, clk_i, rst_ni, (out_valid_q && out_event_q == EV_ERR) |-> (out_value_q == 32'd0 && !out_key_q && !out_done_q), "error event with payload")

endmodule
`default_nettype wire

>>> src/bst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bst_ram #(
  parameter int unsigned WIDTH  = 2,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
